### rtl/core/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gps_pkg.sv
// Shared types, codes and the neighbor move table of the 3D grid path search.
package gps_pkg;

  localparam int COORD_W    = 6;
  localparam int DIST_W     = 10;
  localparam int STEPS_W    = 9;
  localparam int MV_W       = 5;
  localparam int NMOVES     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3;

  localparam logic [STEPS_W-1:0] STEPS_MAX = 9'd511;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] MARK_OPEN    = 2'd0;
  localparam logic [1:0] MARK_BLOCKED = 2'd1;
  localparam logic [1:0] MARK_PATH    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_LAYER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_LAYER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL    = 3'd5;

  // Face moves first, then the edge moves, in the fixed search order.
  localparam logic signed [1:0] MOVE_DL [NMOVES] = '{
    -2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0,
    2'sd1, 2'sd1, -2'sd1, -2'sd1,
    2'sd1, 2'sd1, -2'sd1, -2'sd1,
    2'sd0, 2'sd0, 2'sd0, 2'sd0};
  localparam logic signed [1:0] MOVE_DR [NMOVES] = '{
    2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd0,
    2'sd1, -2'sd1, 2'sd1, -2'sd1,
    2'sd0, 2'sd0, 2'sd0, 2'sd0,
    2'sd1, -2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] MOVE_DC [NMOVES] = '{
    2'sd0, 2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd1,
    2'sd0, 2'sd0, 2'sd0, 2'sd0,
    2'sd1, -2'sd1, 2'sd1, -2'sd1,
    2'sd1, 2'sd1, -2'sd1, -2'sd1};

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] cell_layer;
    logic [2:0] cell_row;
    logic [2:0] cell_col;
    logic       blocked;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         cell_mark;
    logic               found;
    logic [STEPS_W-1:0] steps;
  } out_item_t;

  typedef struct packed {
    logic       rd_en;
    logic       mark_we;
    logic [1:0] mark_wdata;
    logic       closed_we;
    logic       closed_wdata;
    logic       parent_we;
    logic       parent_has;
  } grid_ctl_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } oset_ctl_t;

  typedef struct packed {
    logic done;
    logic empty;
  } oset_sts_t;

  // Squared Euclidean distance from a cell to the goal.
  function automatic logic [DIST_W-1:0] sq_dist(
    input logic signed [COORD_W-1:0] l,
    input logic signed [COORD_W-1:0] r,
    input logic signed [COORD_W-1:0] c,
    input logic [2:0] gl,
    input logic [2:0] gr,
    input logic [2:0] gc);
    logic signed [COORD_W-1:0]   dl;
    logic signed [COORD_W-1:0]   dr;
    logic signed [COORD_W-1:0]   dc;
    logic signed [2*COORD_W-1:0] sum;
    dl  = l - $signed({3'b000, gl});
    dr  = r - $signed({3'b000, gr});
    dc  = c - $signed({3'b000, gc});
    sum = dl * dl + dr * dr + dc * dc;
    return sum[DIST_W-1:0];
  endfunction

endpackage

### rtl/core/gps_grid_store.sv
// Cell mark, closed flag and parent link memories with registered reads.
module gps_grid_store #(
  parameter int AW = 9
) (
  input  logic                clk,
  input  gps_pkg::grid_ctl_t  ctl,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  logic [AW-1:0]       parent_wdata,
  output logic [1:0]          rd_mark,
  output logic                rd_closed,
  output logic                rd_parent_has,
  output logic [AW-1:0]       rd_parent
);

  logic [1:0]  mark_mem   [2**AW];
  logic        closed_mem [2**AW];
  logic [AW:0] parent_mem [2**AW];

  logic [1:0]  rd_mark_r;
  logic        rd_closed_r;
  logic [AW:0] rd_parent_r;

  always_ff @(posedge clk) begin
    if (ctl.mark_we) begin
      mark_mem[wr_addr] <= ctl.mark_wdata;
    end
    if (ctl.closed_we) begin
      closed_mem[wr_addr] <= ctl.closed_wdata;
    end
    if (ctl.parent_we) begin
      parent_mem[wr_addr] <= {ctl.parent_has, parent_wdata};
    end
    if (ctl.rd_en) begin
      rd_mark_r   <= mark_mem[rd_addr];
      rd_closed_r <= closed_mem[rd_addr];
      rd_parent_r <= parent_mem[rd_addr];
    end
  end

  assign rd_mark       = rd_mark_r;
  assign rd_closed     = rd_closed_r;
  assign rd_parent_has = rd_parent_r[AW];
  assign rd_parent     = rd_parent_r[AW-1:0];

endmodule

### rtl/core/gps_open_set.sv
// Open set memory with a sequential minimum scan and swap-with-last removal.
module gps_open_set #(
  parameter int DEPTH = 512,
  parameter int EW    = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gps_pkg::oset_ctl_t ctl,
  input  logic [EW-1:0]      push_entry,
  output gps_pkg::oset_sts_t sts,
  output logic [EW-1:0]      min_entry
);

  localparam int QA_W  = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    O_IDLE  = 4'b0001,
    O_SCAN  = 4'b0010,
    O_FETCH = 4'b0100,
    O_MOVE  = 4'b1000
  } ostate_t;

  ostate_t           state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic              dv_r, dv_nxt;
  logic [QA_W-1:0]   dv_idx_r, dv_idx_nxt;
  logic [EW-1:0]     best_r, best_nxt;
  logic [QA_W-1:0]   best_idx_r, best_idx_nxt;
  logic              done_r, done_nxt;

  logic [EW-1:0]     q_mem [DEPTH];
  logic [EW-1:0]     rdata_r;
  logic              ren, we;
  logic [QA_W-1:0]   raddr, waddr, last_idx;
  logic [EW-1:0]     wdata;

  assign last_idx = QA_W'(cnt_r - 1'b1);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rd_ptr_nxt   = rd_ptr_r;
    dv_nxt       = dv_r;
    dv_idx_nxt   = dv_idx_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    done_nxt     = 1'b0;
    ren          = 1'b0;
    raddr        = '0;
    we           = 1'b0;
    waddr        = '0;
    wdata        = push_entry;
    case (state_r)
      O_IDLE: begin
        if (ctl.clear) begin
          cnt_nxt = '0;
        end else if (ctl.push) begin
          we      = 1'b1;
          waddr   = cnt_r[QA_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end else if (ctl.pop) begin
          ren        = 1'b1;
          raddr      = '0;
          rd_ptr_nxt = CNT_W'(1);
          dv_nxt     = 1'b1;
          dv_idx_nxt = '0;
          state_nxt  = O_SCAN;
        end
      end
      O_SCAN: begin
        if (rd_ptr_r < cnt_r) begin
          ren        = 1'b1;
          raddr      = rd_ptr_r[QA_W-1:0];
          rd_ptr_nxt = rd_ptr_r + 1'b1;
          dv_nxt     = 1'b1;
          dv_idx_nxt = rd_ptr_r[QA_W-1:0];
        end else begin
          dv_nxt = 1'b0;
        end
        if (dv_r) begin
          // The key packs cost, distance and cell, so one compare orders it.
          if (dv_idx_r == '0 || rdata_r < best_r) begin
            best_nxt     = rdata_r;
            best_idx_nxt = dv_idx_r;
          end
          if (dv_idx_r == last_idx) begin
            dv_nxt    = 1'b0;
            state_nxt = O_FETCH;
          end
        end
      end
      O_FETCH: begin
        ren       = 1'b1;
        raddr     = last_idx;
        state_nxt = O_MOVE;
      end
      O_MOVE: begin
        we        = 1'b1;
        waddr     = best_idx_r;
        wdata     = rdata_r;
        cnt_nxt   = cnt_r - 1'b1;
        done_nxt  = 1'b1;
        state_nxt = O_IDLE;
      end
      default: state_nxt = O_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= O_IDLE;
      cnt_r   <= '0;
      dv_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= dv_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    dv_idx_r   <= dv_idx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    if (we) begin
      q_mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_r <= q_mem[raddr];
    end
  end

  assign sts.done  = done_r;
  assign sts.empty = (cnt_r == '0);
  assign min_entry = best_r;

endmodule

### rtl/core/grid_path_search_3d.sv
// A cell write is taken while idle, one write per cycle; a read registers the cell in the
// store, then S_READ registers the result. A search first sweeps every address to clear
// its flags, then per expansion scans the open set and walks the 18 neighbors, and last
// traces the path. Reads and searches hold the input until their result issues.
// Reset is synchronous and active low; afterward a sweep over every cell address clears
// the mark, closed and parent memories, with in_ready held low.
module grid_path_search_3d #(
  parameter int LAYERS = 8,
  parameter int ROWS   = 8,
  parameter int COLS   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gps_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gps_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gps_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Cells are addressed as packed {layer, row, column} fields, so address order
  // matches the layer, row, column tie-break of the search key.
  localparam int LW     = $clog2(LAYERS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLS);
  localparam int AW     = LW + RW + CW;
  localparam int NCELLS = LAYERS * ROWS * COLS;
  localparam int COST_W = $clog2(NCELLS);
  localparam int EW     = COST_W + gps_pkg::DIST_W + AW;
  localparam int EXT_W  = COST_W + gps_pkg::STEPS_W;
  localparam int CO_W   = gps_pkg::COORD_W;

  typedef enum logic [11:0] {
    S_INIT      = 12'b000000000001,
    S_IDLE      = 12'b000000000010,
    S_READ      = 12'b000000000100,
    S_CLEAR     = 12'b000000001000,
    S_SEED      = 12'b000000010000,
    S_NEXT      = 12'b000000100000,
    S_POPW      = 12'b000001000000,
    S_CHECK     = 12'b000010000000,
    S_EXPAND    = 12'b000100000000,
    S_TRACE     = 12'b001000000000,
    S_TRACE_CHK = 12'b010000000000,
    S_DONE      = 12'b100000000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [AW-1:0]                 sweep_r, sweep_nxt;
  logic [AW-1:0]                 cur_addr_r, cur_addr_nxt;
  logic [COST_W-1:0]             cur_cost_r, cur_cost_nxt;
  logic [gps_pkg::MV_W-1:0]      mv_r, mv_nxt;
  logic                          pv_r, pv_nxt;
  logic [AW-1:0]                 nb_addr_r, nb_addr_nxt;
  logic [gps_pkg::DIST_W-1:0]    nb_dist_r, nb_dist_nxt;
  logic [AW-1:0]                 p_addr_r, p_addr_nxt;
  logic [COST_W-1:0]             hops_r, hops_nxt;
  logic                          res_found_r, res_found_nxt;
  logic [gps_pkg::STEPS_W-1:0]   res_steps_r, res_steps_nxt;
  logic                          rd_ok_r, rd_ok_nxt;
  logic                          out_valid_r, out_valid_nxt;
  gps_pkg::out_item_t            out_data_r, out_data_nxt;

  logic [2:0] start_l_r, start_r_r, start_c_r;
  logic [2:0] goal_l_r, goal_r_r, goal_c_r;

  // Memory and open-set control.
  gps_pkg::grid_ctl_t  gctl;
  logic [AW-1:0]       g_rd_addr, g_wr_addr;
  logic [1:0]          rd_mark;
  logic                rd_closed, rd_parent_has;
  logic [AW-1:0]       rd_parent;
  gps_pkg::oset_ctl_t  octl;
  gps_pkg::oset_sts_t  osts;
  logic [EW-1:0]       push_entry, min_entry;

  // Coordinates carried as small signed values so neighbor steps can go negative.
  logic signed [CO_W-1:0] in_l, in_r, in_c;
  logic signed [CO_W-1:0] st_l, st_r, st_c;
  logic [CO_W-1:0]        gl_w, gr_w, gc_w;
  logic signed [CO_W-1:0] cur_l, cur_r, cur_c;
  logic signed [CO_W-1:0] nl, nr, nc;
  logic                   in_ok, start_ok, goal_ok, nb_ok, mv_live, eligible;
  logic [AW-1:0]          in_addr, start_addr, goal_addr, nb_addr;
  logic [gps_pkg::MV_W-1:0] mv_idx;
  logic [EXT_W-1:0]       hops_ext;
  logic [gps_pkg::STEPS_W-1:0] steps_sat;

  assign in_l = CO_W'(in_data.cell_layer);
  assign in_r = CO_W'(in_data.cell_row);
  assign in_c = CO_W'(in_data.cell_col);
  assign st_l = CO_W'(start_l_r);
  assign st_r = CO_W'(start_r_r);
  assign st_c = CO_W'(start_c_r);
  assign gl_w = CO_W'(goal_l_r);
  assign gr_w = CO_W'(goal_r_r);
  assign gc_w = CO_W'(goal_c_r);

  assign in_ok = ($unsigned(in_l) < CO_W'(LAYERS)) && ($unsigned(in_r) < CO_W'(ROWS)) &&
                 ($unsigned(in_c) < CO_W'(COLS));
  assign start_ok = ($unsigned(st_l) < CO_W'(LAYERS)) && ($unsigned(st_r) < CO_W'(ROWS)) &&
                    ($unsigned(st_c) < CO_W'(COLS));
  assign goal_ok = (CO_W'(goal_l_r) < CO_W'(LAYERS)) && (CO_W'(goal_r_r) < CO_W'(ROWS)) &&
                   (CO_W'(goal_c_r) < CO_W'(COLS));

  assign in_addr    = {in_l[LW-1:0], in_r[RW-1:0], in_c[CW-1:0]};
  assign start_addr = {st_l[LW-1:0], st_r[RW-1:0], st_c[CW-1:0]};
  assign goal_addr  = {gl_w[LW-1:0], gr_w[RW-1:0], gc_w[CW-1:0]};

  // The neighbor being examined this cycle: current cell plus one table move.
  assign mv_live = (mv_r < gps_pkg::MV_W'(gps_pkg::NMOVES));
  assign mv_idx  = mv_live ? mv_r : '0;
  assign cur_l   = CO_W'(cur_addr_r[AW-1 -: LW]);
  assign cur_r   = CO_W'(cur_addr_r[CW +: RW]);
  assign cur_c   = CO_W'(cur_addr_r[CW-1:0]);
  assign nl      = cur_l + CO_W'(gps_pkg::MOVE_DL[mv_idx]);
  assign nr      = cur_r + CO_W'(gps_pkg::MOVE_DR[mv_idx]);
  assign nc      = cur_c + CO_W'(gps_pkg::MOVE_DC[mv_idx]);
  assign nb_ok   = !nl[CO_W-1] && ($unsigned(nl) < CO_W'(LAYERS)) &&
                   !nr[CO_W-1] && ($unsigned(nr) < CO_W'(ROWS)) &&
                   !nc[CO_W-1] && ($unsigned(nc) < CO_W'(COLS));
  assign nb_addr = {nl[LW-1:0], nr[RW-1:0], nc[CW-1:0]};

  // A neighbor read last cycle joins the open set when it is passable and untouched.
  assign eligible = pv_r && (rd_mark != gps_pkg::MARK_BLOCKED) && !rd_closed && !rd_parent_has;

  assign hops_ext  = EXT_W'(hops_r);
  assign steps_sat = (hops_ext > EXT_W'(gps_pkg::STEPS_MAX)) ? gps_pkg::STEPS_MAX :
                     hops_ext[gps_pkg::STEPS_W-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    cur_addr_nxt  = cur_addr_r;
    cur_cost_nxt  = cur_cost_r;
    mv_nxt        = mv_r;
    pv_nxt        = pv_r;
    nb_addr_nxt   = nb_addr_r;
    nb_dist_nxt   = nb_dist_r;
    p_addr_nxt    = p_addr_r;
    hops_nxt      = hops_r;
    res_found_nxt = res_found_r;
    res_steps_nxt = res_steps_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    gctl          = '0;
    g_rd_addr     = '0;
    g_wr_addr     = '0;
    octl          = '0;
    push_entry    = {COST_W'(cur_cost_r + 1'b1), nb_dist_r, nb_addr_r};

    case (state_r)
      // After reset every cell becomes open and every search flag is cleared.
      S_INIT: begin
        gctl.mark_we   = 1'b1;
        gctl.closed_we = 1'b1;
        gctl.parent_we = 1'b1;
        g_wr_addr      = sweep_r;
        sweep_nxt      = sweep_r + 1'b1;
        if (sweep_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.kind)
            gps_pkg::KIND_WRITE: begin
              gctl.mark_we    = in_ok;
              gctl.mark_wdata = in_data.blocked ? gps_pkg::MARK_BLOCKED : gps_pkg::MARK_OPEN;
              g_wr_addr       = in_addr;
            end
            gps_pkg::KIND_READ: begin
              gctl.rd_en = in_ok;
              g_rd_addr  = in_addr;
              rd_ok_nxt  = in_ok;
              state_nxt  = S_READ;
            end
            gps_pkg::KIND_SEARCH: begin
              if (start_ok && goal_ok) begin
                sweep_nxt = '0;
                state_nxt = S_CLEAR;
              end else begin
                res_found_nxt = 1'b0;
                res_steps_nxt = '0;
                state_nxt     = S_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      // Read data is registered in the store and holds until the result leaves.
      S_READ: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.cell_mark = rd_ok_r ? rd_mark : gps_pkg::MARK_OPEN;
          out_data_nxt.found     = 1'b0;
          out_data_nxt.steps     = '0;
          state_nxt              = S_IDLE;
        end
      end
      // Each search starts from clean closed flags, parent links and open set.
      S_CLEAR: begin
        gctl.closed_we = 1'b1;
        gctl.parent_we = 1'b1;
        g_wr_addr      = sweep_r;
        octl.clear     = 1'b1;
        sweep_nxt      = sweep_r + 1'b1;
        if (sweep_r == {AW{1'b1}}) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        octl.push  = 1'b1;
        push_entry = {COST_W'(0),
                      gps_pkg::sq_dist(st_l, st_r, st_c, goal_l_r, goal_r_r, goal_c_r),
                      start_addr};
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        if (osts.empty) begin
          res_found_nxt = 1'b0;
          res_steps_nxt = '0;
          state_nxt     = S_DONE;
        end else begin
          octl.pop  = 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        if (osts.done) begin
          cur_addr_nxt = min_entry[AW-1:0];
          cur_cost_nxt = min_entry[EW-1 -: COST_W];
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cur_addr_r == goal_addr) begin
          p_addr_nxt = cur_addr_r;
          hops_nxt   = '0;
          state_nxt  = S_TRACE;
        end else begin
          gctl.closed_we    = 1'b1;
          gctl.closed_wdata = 1'b1;
          g_wr_addr         = cur_addr_r;
          mv_nxt            = '0;
          pv_nxt            = 1'b0;
          state_nxt         = S_EXPAND;
        end
      end
      // Two-stage walk over the moves: read the neighbor's state, then decide.
      S_EXPAND: begin
        gctl.parent_we  = eligible;
        gctl.parent_has = 1'b1;
        g_wr_addr       = nb_addr_r;
        octl.push       = eligible;
        if (mv_live) begin
          gctl.rd_en  = nb_ok;
          g_rd_addr   = nb_addr;
          pv_nxt      = nb_ok;
          nb_addr_nxt = nb_addr;
          nb_dist_nxt = gps_pkg::sq_dist(nl, nr, nc, goal_l_r, goal_r_r, goal_c_r);
          mv_nxt      = mv_r + 1'b1;
        end else begin
          pv_nxt    = 1'b0;
          state_nxt = S_NEXT;
        end
      end
      S_TRACE: begin
        gctl.mark_we    = 1'b1;
        gctl.mark_wdata = gps_pkg::MARK_PATH;
        g_wr_addr       = p_addr_r;
        gctl.rd_en      = 1'b1;
        g_rd_addr       = p_addr_r;
        state_nxt       = S_TRACE_CHK;
      end
      S_TRACE_CHK: begin
        if (rd_parent_has) begin
          p_addr_nxt = rd_parent;
          hops_nxt   = hops_r + 1'b1;
          state_nxt  = S_TRACE;
        end else begin
          res_found_nxt = 1'b1;
          res_steps_nxt = steps_sat;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.cell_mark = gps_pkg::MARK_OPEN;
          out_data_nxt.found     = res_found_r;
          out_data_nxt.steps     = res_steps_r;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      mv_r        <= '0;
      start_l_r   <= 3'd0;
      start_r_r   <= 3'd0;
      start_c_r   <= 3'd0;
      goal_l_r    <= 3'd7;
      goal_r_r    <= 3'd7;
      goal_c_r    <= 3'd7;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
      mv_r        <= mv_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gps_pkg::CFG_START_LAYER: start_l_r <= cfg_data;
          gps_pkg::CFG_START_ROW:   start_r_r <= cfg_data;
          gps_pkg::CFG_START_COL:   start_c_r <= cfg_data;
          gps_pkg::CFG_GOAL_LAYER:  goal_l_r  <= cfg_data;
          gps_pkg::CFG_GOAL_ROW:    goal_r_r  <= cfg_data;
          gps_pkg::CFG_GOAL_COL:    goal_c_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_addr_r  <= cur_addr_nxt;
    cur_cost_r  <= cur_cost_nxt;
    nb_addr_r   <= nb_addr_nxt;
    nb_dist_r   <= nb_dist_nxt;
    p_addr_r    <= p_addr_nxt;
    hops_r      <= hops_nxt;
    res_found_r <= res_found_nxt;
    res_steps_r <= res_steps_nxt;
    rd_ok_r     <= rd_ok_nxt;
    out_data_r  <= out_data_nxt;
  end

  gps_grid_store #(
    .AW (AW)
  ) u_grid (
    .clk           (clk),
    .ctl           (gctl),
    .rd_addr       (g_rd_addr),
    .wr_addr       (g_wr_addr),
    .parent_wdata  (cur_addr_r),
    .rd_mark       (rd_mark),
    .rd_closed     (rd_closed),
    .rd_parent_has (rd_parent_has),
    .rd_parent     (rd_parent)
  );

  gps_open_set #(
    .DEPTH (NCELLS),
    .EW    (EW)
  ) u_oset (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (octl),
    .push_entry (push_entry),
    .sts        (osts),
    .min_entry  (min_entry)
  );

endmodule

### rtl/core/gps_checker.sv
// Port-level checks on the grid path search, bound to its top level.
`include "assert_macros.svh"

module gps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input gps_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input gps_pkg::out_item_t out_data
);

  `GPS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result transaction changed while stalled")
  `GPS_ASSERT_NXT(a_write_ready, in_valid && in_ready && in_data.kind == gps_pkg::KIND_WRITE, in_ready, "block went busy after a cell write")
  `GPS_ASSERT_NXT(a_read_busy, in_valid && in_ready && in_data.kind == gps_pkg::KIND_READ, !in_ready, "block took a transaction while a read was pending")
  `GPS_ASSERT_IMP(a_steps_found, out_valid && out_data.steps != '0, out_data.found && out_data.cell_mark == gps_pkg::MARK_OPEN, "nonzero step count without a found search result")

endmodule

bind grid_path_search_3d gps_checker u_gps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
